/* src/sdtq_pkg.sv */
// Shared types and codes for the sorted deadline timer queue.
// Depends on nothing; used by the top level and by sdtq_cell.
`timescale 1ns / 1ps

package sdtq_pkg;

	// Most expired beats reported by one process request
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_SCHEDULE = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_PROCESS  = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_SCHEDULED = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_EXPIRED   = 3'd3,
		KIND_TIME_LEFT = 3'd4,
		KIND_EMPTY     = 3'd5
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic remove;
		logic pop;
	} cell_cmd_t;

endpackage

/* src/sorted_deadline_timer_queue.sv */
// Top level of the sorted deadline timer queue: control sequencer, allocator
// and the chain of cells. Depends on sdtq_pkg, sdtq_alloc and sdtq_cell.
`timescale 1ns / 1ps
//
// Usage
//   Requests arrive on the s_ channel: tuser carries the operation, tdata the
//   deadline, slot and current time. Results leave on the m_ channel with the
//   result kind in tuser and tlast on the final beat a request causes.
//   The pending timers sit in a chain of cells kept sorted by deadline, the
//   earliest in cell 0; every cell compares its deadline in parallel, so an
//   insert, cancel or pop shifts all entries behind the changed position by one place.
//   A request is taken in the idle state and executed in the execute state,
//   which waits while a result beat is still held in the output register.
//   Process emits one expired beat per cycle while the receiver takes them,
//   at most 32 per request. The sequencer holds one request at a time;
//   s_tready is high whenever it is idle, even while a result beat waits
//   in the output register.
//   When the receiver stalls, the held beat stays on m_ and execution waits;
//   no beat is dropped. Reset empties the chain and frees every slot; no
//   clearing pass is needed, the block is ready as soon as reset is released.
//
module sorted_deadline_timer_queue #(
	parameter int NUM_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // deadline[31:0], slot[37:32], now[69:38], zero pad
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // slot_id[4:0], remaining[36:5], zero pad
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	sdtq_pkg::state_t state_q, state_d;

	// Request registers
	sdtq_pkg::op_t                 op_q;
	logic [31:0]                   deadline_q;
	logic [5:0]                    slot_q;
	logic [31:0]                   now_q;
	logic [sdtq_pkg::CNT_W-1:0]    cnt_q, cnt_d;

	// Output register
	logic                 out_valid_q;
	sdtq_pkg::kind_t      out_kind_q;
	logic [4:0]           out_id_q;
	logic [31:0]          out_rem_q;
	logic                 out_last_q;
	logic                 load;
	sdtq_pkg::kind_t      load_kind;
	logic [SLOT_W-1:0]    load_id;
	logic [31:0]          load_rem;
	logic                 load_last;
	logic [63:0]          load_id_wide;
	logic                 out_free;

	// Chain and allocator signals
	sdtq_pkg::cell_cmd_t   cmd;
	logic [31:0]           key;
	logic [NUM_SLOTS-1:0]  c_valid;
	logic [31:0]           c_dl [NUM_SLOTS];
	logic [SLOT_W-1:0]     c_id [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  c_le;
	logic [NUM_SLOTS-1:0]  c_shift;
	logic                  set_en;
	logic                  clr_en;
	logic [SLOT_W-1:0]     clr_idx;
	logic [SLOT_W-1:0]     free_idx;
	logic                  full;
	logic [NUM_SLOTS-1:0]  used;
	logic                  cancel_ok;
	logic                  head_due;
	logic                  more_due;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == sdtq_pkg::ST_IDLE);
	assign key      = (op_q == sdtq_pkg::OP_SCHEDULE) ? deadline_q : now_q;

	// Allocator
	sdtq_alloc #(
		.NUM_SLOTS(NUM_SLOTS),
		.SLOT_W   (SLOT_W)
	) u_alloc (
		.clk     (clk),
		.arst_n  (arst_n),
		.set_en  (set_en),
		.clr_en  (clr_en),
		.clr_idx (clr_idx),
		.free_idx(free_idx),
		.full    (full),
		.used    (used)
	);

	// Sorted chain, cell 0 holds the earliest deadline
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		logic              lv, rv, lle, shin;
		logic [31:0]       ldl, rdl;
		logic [SLOT_W-1:0] lid, rid;
		if (g == 0) begin : g_first
			assign lv   = 1'b0;
			assign ldl  = '0;
			assign lid  = '0;
			assign lle  = 1'b1;
			assign shin = 1'b0;
		end else begin : g_mid
			assign lv   = c_valid[g-1];
			assign ldl  = c_dl[g-1];
			assign lid  = c_id[g-1];
			assign lle  = c_le[g-1];
			assign shin = c_shift[g-1];
		end
		if (g == NUM_SLOTS - 1) begin : g_last
			assign rv  = 1'b0;
			assign rdl = '0;
			assign rid = '0;
		end else begin : g_inner
			assign rv  = c_valid[g+1];
			assign rdl = c_dl[g+1];
			assign rid = c_id[g+1];
		end
		sdtq_cell #(
			.SLOT_W(SLOT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key),
			.new_id     (free_idx),
			.match_id   (slot_q[SLOT_W-1:0]),
			.left_valid (lv),
			.left_dl    (ldl),
			.left_id    (lid),
			.left_le    (lle),
			.shift_in   (shin),
			.right_valid(rv),
			.right_dl   (rdl),
			.right_id   (rid),
			.valid      (c_valid[g]),
			.dl         (c_dl[g]),
			.id         (c_id[g]),
			.le         (c_le[g]),
			.shift_out  (c_shift[g])
		);
	end

	assign cancel_ok = ({1'b0, slot_q} < 7'(NUM_SLOTS)) && used[slot_q[SLOT_W-1:0]];
	assign head_due  = c_le[0] && (cnt_q < sdtq_pkg::CNT_W'(sdtq_pkg::MAX_RESULTS));
	assign more_due  = (NUM_SLOTS > 1) && c_le[NUM_SLOTS > 1 ? 1 : 0]
		&& (cnt_q < sdtq_pkg::CNT_W'(sdtq_pkg::MAX_RESULTS - 1));

	// Sequencer: next state, chain commands and result beat
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		set_en    = 1'b0;
		clr_en    = 1'b0;
		clr_idx   = c_id[0];
		load      = 1'b0;
		load_kind = sdtq_pkg::KIND_EMPTY;
		load_id   = '0;
		load_rem  = '0;
		load_last = 1'b1;
		case (state_q)
			sdtq_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (s_tvalid) begin
					state_d = sdtq_pkg::ST_EXEC;
				end
			end
			sdtq_pkg::ST_EXEC: begin
				case (op_q)
					sdtq_pkg::OP_SCHEDULE: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = sdtq_pkg::ST_IDLE;
							if (full) begin
								load_kind = sdtq_pkg::KIND_FULL;
							end else begin
								cmd.insert = 1'b1;
								set_en     = 1'b1;
								load_kind  = sdtq_pkg::KIND_SCHEDULED;
								load_id    = free_idx;
							end
						end
					end
					sdtq_pkg::OP_CANCEL: begin
						if (!cancel_ok) begin
							state_d = sdtq_pkg::ST_IDLE;
						end else if (out_free) begin
							cmd.remove = 1'b1;
							clr_en     = 1'b1;
							clr_idx    = slot_q[SLOT_W-1:0];
							load       = 1'b1;
							load_kind  = sdtq_pkg::KIND_CANCELLED;
							load_id    = slot_q[SLOT_W-1:0];
							state_d    = sdtq_pkg::ST_IDLE;
						end
					end
					sdtq_pkg::OP_PROCESS: begin
						if (!head_due) begin
							state_d = sdtq_pkg::ST_IDLE;
						end else if (out_free) begin
							cmd.pop   = 1'b1;
							clr_en    = 1'b1;
							load      = 1'b1;
							load_kind = sdtq_pkg::KIND_EXPIRED;
							load_id   = c_id[0];
							load_last = !more_due;
							cnt_d     = cnt_q + 1'b1;
							if (!more_due) begin
								state_d = sdtq_pkg::ST_IDLE;
							end
						end
					end
					default: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = sdtq_pkg::ST_IDLE;
							if (c_valid[0]) begin
								load_kind = sdtq_pkg::KIND_TIME_LEFT;
								load_rem  = (c_dl[0] > now_q) ? (c_dl[0] - now_q) : '0;
							end
						end
					end
				endcase
			end
			default: begin
				state_d = sdtq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdtq_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q       <= sdtq_pkg::op_t'(s_tuser);
			deadline_q <= s_tdata[31:0];
			slot_q     <= s_tdata[37:32];
			now_q      <= s_tdata[69:38];
		end
	end

	// Output register
	assign load_id_wide = 64'(load_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= load_kind;
			out_id_q   <= load_id_wide[4:0];
			out_rem_q  <= load_rem;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_rem_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

/* src/sdtq_cell.sv */
// One position of the sorted chain: a valid flag, a deadline and a slot id.
// Depends on sdtq_pkg for the command struct.
`timescale 1ns / 1ps

module sdtq_cell #(
	parameter int SLOT_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sdtq_pkg::cell_cmd_t   cmd,
	input  logic [31:0]           key,
	input  logic [SLOT_W-1:0]     new_id,
	input  logic [SLOT_W-1:0]     match_id,
	// left neighbour (earlier deadline)
	input  logic                  left_valid,
	input  logic [31:0]           left_dl,
	input  logic [SLOT_W-1:0]     left_id,
	input  logic                  left_le,
	input  logic                  shift_in,
	// right neighbour (later deadline)
	input  logic                  right_valid,
	input  logic [31:0]           right_dl,
	input  logic [SLOT_W-1:0]     right_id,
	output logic                  valid,
	output logic [31:0]           dl,
	output logic [SLOT_W-1:0]     id,
	output logic                  le,
	output logic                  shift_out
);

	logic              valid_q;
	logic [31:0]       dl_q;
	logic [SLOT_W-1:0] id_q;
	logic              match;
	logic              take_new;
	logic              take_left;
	logic              take_right;

	assign le        = valid_q && (dl_q <= key);
	assign match     = valid_q && (id_q == match_id);
	assign shift_out = shift_in || match;

	// Insert opens a gap at the first later entry; remove and pop close one
	always_comb begin
		take_new   = cmd.insert && !le && left_le;
		take_left  = cmd.insert && !le && !left_le;
		take_right = cmd.pop || (cmd.remove && shift_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			dl_q <= key;
			id_q <= new_id;
		end else if (take_left) begin
			dl_q <= left_dl;
			id_q <= left_id;
		end else if (take_right) begin
			dl_q <= right_dl;
			id_q <= right_id;
		end
	end

	assign valid = valid_q;
	assign dl    = dl_q;
	assign id    = id_q;

endmodule

/* src/sdtq_alloc.sv */
// Slot allocator: in-use flags and lowest-free-slot search.
// Self-contained; instantiated by the top level.
`timescale 1ns / 1ps

module sdtq_alloc #(
	parameter int NUM_SLOTS = 32,
	parameter int SLOT_W    = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  set_en,
	input  logic                  clr_en,
	input  logic [SLOT_W-1:0]     clr_idx,
	output logic [SLOT_W-1:0]     free_idx,
	output logic                  full,
	output logic [NUM_SLOTS-1:0]  used
);

	logic [NUM_SLOTS-1:0] used_q;

	// Lowest clear flag wins
	always_comb begin
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		full = &used_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (set_en) begin
				used_q[free_idx] <= 1'b1;
			end
			if (clr_en) begin
				used_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign used = used_q;

endmodule
